>>> sv/pcxrle_pkg.sv
// ----------------------------------------------------------------------------
// PCX RLE pixel decoder package
// Shared types and constants for the decoder front end, back end and top level.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

	// Field widths fixed by the stream and register formats.
	localparam int BYTE_W     = 8;
	localparam int RUN_W      = 6;
	localparam int DIM_W      = 11;
	localparam int OFS_W      = 10;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 11;
	localparam int CNT_W      = 21;
	localparam int PIX_ADDR_W = 20;
	localparam int PROD_W     = 23;
	localparam int SUM_W      = 24;
	localparam int CFG_IDX_W  = 3;

	// A byte at or above this mark is a run header.
	localparam logic [BYTE_W-1:0] RUN_MARK = 8'd192;
	localparam logic [BYTE_W-1:0] RUN_MASK = 8'h3F;

	// Image dimension limits.
	localparam logic [DIM_W-1:0] DIM_MIN = 11'd1;
	localparam logic [DIM_W-1:0] DIM_MAX = 11'd1024;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE  = 3'd4;

	// Register values after reset.
	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd320;
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd240;
	localparam logic [OFS_W-1:0] RST_OFFSET_X     = 10'd0;
	localparam logic [OFS_W-1:0] RST_OFFSET_Y     = 10'd0;
	localparam logic [DIM_W-1:0] RST_LINE_STRIDE  = 11'd320;

	// One beat of the compressed input stream.
	typedef struct packed {
		logic [BYTE_W-1:0] code_byte;
		logic              frame_start;
	} code_item_t;

	// One beat of decoded pixel output.
	typedef struct packed {
		logic [PIX_ADDR_W-1:0] pixel_address;
		logic [BYTE_W-1:0]     pixel_value;
		logic                  last_of_run;
		logic                  image_done;
	} pixel_item_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [OFS_W-1:0] offset_x;
		logic [OFS_W-1:0] offset_y;
		logic [DIM_W-1:0] line_stride;
	} cfg_t;

	// Command from the front end to the back end: optional position clear,
	// then count copies of value.
	typedef struct packed {
		logic              clear;
		logic [BYTE_W-1:0] value;
		logic [RUN_W-1:0]  count;
	} cmd_t;

	// Back end sequencer states.
	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

endpackage

>>> sv/pcxrle_fifo.sv
// ----------------------------------------------------------------------------
// PCX RLE small queue
// Register-based first-in first-out queue with full, empty and fill level.
// ----------------------------------------------------------------------------
module pcxrle_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PtrW = $clog2(DEPTH),
	localparam int LvlW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty,
	output logic [LvlW-1:0]  level
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [LvlW-1:0]  level_q;
	logic             do_wr;
	logic             do_rd;

	// Qualify the strobes against the queue state.
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	assign full    = (level_q == LvlW'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				level_q <= level_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/pcxrle_front.sv
// ----------------------------------------------------------------------------
// PCX RLE front end
// Accepts code bytes, tracks run headers and issues commands for the back end.
// ----------------------------------------------------------------------------
module pcxrle_front import pcxrle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  code_item_t code,
	output logic       full,
	input  logic       cmd_full,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic             awaiting_q;
	logic [RUN_W-1:0] pending_q;
	logic             accept;
	logic             awaiting_eff;
	logic [RUN_W-1:0] pending_eff;
	logic             awaiting_nxt;
	logic [RUN_W-1:0] pending_nxt;
	logic [RUN_W-1:0] count;

	// A beat is taken whenever the command queue has room.
	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// Frame start drops any pending run before the byte is looked at.
	assign awaiting_eff = code.frame_start ? 1'b0 : awaiting_q;
	assign pending_eff  = code.frame_start ? '0 : pending_q;

	// Classify the byte: run value, literal pixel or run header.
	always_comb begin
		count        = '0;
		awaiting_nxt = 1'b0;
		pending_nxt  = '0;
		if (awaiting_eff) begin
			count = pending_eff;
		end else if (code.code_byte < RUN_MARK) begin
			count = RUN_W'(1);
		end else begin
			awaiting_nxt = 1'b1;
			pending_nxt  = RUN_W'(code.code_byte & RUN_MASK);
		end
	end

	// Only bytes that make pixels or clear the position need the back end.
	assign cmd_push  = accept && (code.frame_start || (count != '0));
	assign cmd.clear = code.frame_start;
	assign cmd.value = code.code_byte;
	assign cmd.count = count;

	// Run header tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			pending_q  <= '0;
		end else if (accept) begin
			awaiting_q <= awaiting_nxt;
			pending_q  <= pending_nxt;
		end
	end

endmodule

>>> sv/pcxrle_back.sv
// ----------------------------------------------------------------------------
// PCX RLE back end
// Expands commands into pixels, tracks the raster position and computes the
// framebuffer address through a one-stage multiply pipeline.
// ----------------------------------------------------------------------------
module pcxrle_back import pcxrle_pkg::*; #(
	parameter int ADDRESS_BITS = 20,
	parameter int OUT_DEPTH = 4,
	localparam int LvlW = $clog2(OUT_DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  cmd_t            cmd,
	input  logic            cmd_empty,
	output logic            cmd_pop,
	input  logic [LvlW-1:0] out_level,
	output logic            out_push,
	output pixel_item_t     out_item
);

	localparam logic [SUM_W-1:0] ADDR_MASK = SUM_W'((64'd1 << ADDRESS_BITS) - 64'd1);

	back_state_t       state_q;
	back_state_t       state_nxt;
	logic [BYTE_W-1:0] value_q;
	logic [RUN_W-1:0]  remain_q;
	logic [COL_W-1:0]  column_q;
	logic [ROW_W-1:0]  row_q;
	logic [CNT_W-1:0]  written_q;
	logic [DIM_W-1:0]  width_q;
	logic [CNT_W-1:0]  total_q;
	logic [DIM_W-1:0]  width_clamp;
	logic [DIM_W-1:0]  height_clamp;

	logic              credit_ok;
	logic              image_full;
	logic              fire;
	logic              last_px;
	logic              done_px;
	logic              wrap;

	logic              valid_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [DIM_W-1:0]  colsum_s1;
	logic [BYTE_W-1:0] value_s1;
	logic              last_s1;
	logic              done_s1;
	logic [SUM_W-1:0]  addr_sum;

	// Clamp the image dimensions into the legal range.
	always_comb begin
		width_clamp = cfg.image_width;
		if (cfg.image_width == '0) begin
			width_clamp = DIM_MIN;
		end else if (cfg.image_width > DIM_MAX) begin
			width_clamp = DIM_MAX;
		end
		height_clamp = cfg.image_height;
		if (cfg.image_height == '0) begin
			height_clamp = DIM_MIN;
		end else if (cfg.image_height > DIM_MAX) begin
			height_clamp = DIM_MAX;
		end
	end

	// Derived geometry, refreshed every cycle from the register file.
	always_ff @(posedge clk) begin
		width_q <= width_clamp;
		total_q <= CNT_W'(width_clamp * height_clamp);
	end

	// Issue a pixel only when the output queue is sure to have room for it.
	assign credit_ok  = (({1'b0, out_level} + (LvlW + 1)'(valid_s1)) <
		(LvlW + 1)'(OUT_DEPTH));
	assign image_full = (written_q >= total_q);
	assign done_px    = ((written_q + 1'b1) == total_q);
	assign last_px    = (remain_q == RUN_W'(1)) || done_px;
	assign wrap       = (({1'b0, column_q} + 1'b1) >= width_q);

	// Sequencer next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!cmd_empty && (cmd.count != '0)) begin
					state_nxt = BK_RUN;
				end
			end
			BK_RUN: begin
				if (image_full || (fire && last_px)) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		cmd_pop = 1'b0;
		fire    = 1'b0;
		unique case (state_q)
			BK_IDLE: cmd_pop = !cmd_empty;
			BK_RUN:  fire    = credit_ok && !image_full;
			default: begin
				cmd_pop = 1'b0;
				fire    = 1'b0;
			end
		endcase
	end

	// Command load and raster position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			remain_q  <= '0;
			column_q  <= '0;
			row_q     <= '0;
			written_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd_pop) begin
				remain_q <= cmd.count;
				if (cmd.clear) begin
					column_q  <= '0;
					row_q     <= '0;
					written_q <= '0;
				end
			end else if (fire) begin
				remain_q  <= remain_q - 1'b1;
				written_q <= written_q + 1'b1;
				if (wrap) begin
					column_q <= '0;
					row_q    <= row_q + 1'b1;
				end else begin
					column_q <= column_q + 1'b1;
				end
			end
		end
	end

	// Pixel value of the current command.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			value_q <= cmd.value;
		end
	end

	// Stage 1: line base product and column sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			prod_s1   <= PROD_W'(({1'b0, row_q} + (ROW_W + 1)'(cfg.offset_y)) *
				cfg.line_stride);
			colsum_s1 <= {1'b0, column_q} + DIM_W'(cfg.offset_x);
			value_s1  <= value_q;
			last_s1   <= last_px;
			done_s1   <= done_px;
		end
	end

	// Final address add, wrapped to the framebuffer address space.
	assign addr_sum = (SUM_W'(prod_s1) + SUM_W'(colsum_s1)) & ADDR_MASK;

	assign out_push               = valid_s1;
	assign out_item.pixel_address = addr_sum[PIX_ADDR_W-1:0];
	assign out_item.pixel_value   = value_s1;
	assign out_item.last_of_run   = last_s1;
	assign out_item.image_done    = done_s1;

endmodule

>>> sv/pcx_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// PCX RLE pixel decoder
// Decodes a PCX run-length byte stream into framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Usage: compressed bytes enter on the code queue port (push/full), one beat
// per byte; frame_start on a beat resets the raster position and any pending
// run before that byte is decoded. Pixel writes leave on the pixel queue port
// (empty/pop), oldest first, each with its framebuffer address, value, a
// last_of_run flag and an image_done flag on the final pixel of the image.
// Registers are written through cfg_valid/cfg_ready, which is always ready.
// A literal byte passes the command queue, the back end's command load, the
// address stage and the pixel queue before its pixel shows. The back end loads
// each command, then issues one pixel per cycle while the pixel queue has room
// and takes no new command until the run is through; the single address
// multiplier and the pixel sequencer set this pace. A run header alone sends no
// command unless it also starts a frame, which loads a clear in the back end.
// When pop stays low, the four-entry pixel queue fills, the back end holds,
// and the four-entry command queue then raises full. Reset empties both queues,
// clears the raster position and loads the default register values.
// ----------------------------------------------------------------------------
module pcx_rle_pixel_decoder import pcxrle_pkg::*; #(
	parameter int ADDRESS_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  code_item_t           code,
	output logic                 full,
	output logic                 empty,
	input  logic                 pop,
	output pixel_item_t          pixel,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	localparam int CmdDepth = 4;
	localparam int OutDepth = 4;
	localparam int CmdLvlW  = $clog2(CmdDepth + 1);
	localparam int OutLvlW  = $clog2(OutDepth + 1);

	cfg_t               cfg_q;
	logic               cmd_push;
	cmd_t               cmd_in;
	cmd_t               cmd_out;
	logic               cmd_full;
	logic               cmd_empty;
	logic               cmd_pop;
	logic [CmdLvlW-1:0] cmd_level;
	logic               out_push;
	pixel_item_t        out_item;
	logic               out_full;
	logic [OutLvlW-1:0] out_level;

	// Register file; a beat is taken every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_IMAGE_WIDTH;
			cfg_q.image_height <= RST_IMAGE_HEIGHT;
			cfg_q.offset_x     <= RST_OFFSET_X;
			cfg_q.offset_y     <= RST_OFFSET_Y;
			cfg_q.line_stride  <= RST_LINE_STRIDE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data;
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
				CFG_OFFSET_X:     cfg_q.offset_x     <= cfg_data[OFS_W-1:0];
				CFG_OFFSET_Y:     cfg_q.offset_y     <= cfg_data[OFS_W-1:0];
				CFG_LINE_STRIDE:  cfg_q.line_stride  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Byte classification.
	pcxrle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.code     (code),
		.full     (full),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	// Command queue between the front and back ends.
	pcxrle_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CmdDepth)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.full    (cmd_full),
		.empty   (cmd_empty),
		.level   (cmd_level)
	);

	// Pixel expansion and addressing.
	pcxrle_back #(
		.ADDRESS_BITS (ADDRESS_BITS),
		.OUT_DEPTH    (OutDepth)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_level (out_level),
		.out_push  (out_push),
		.out_item  (out_item)
	);

	// Result queue toward the pixel consumer.
	pcxrle_fifo #(
		.WIDTH ($bits(pixel_item_t)),
		.DEPTH (OutDepth)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_item),
		.rd_en   (pop),
		.rd_data (pixel),
		.full    (out_full),
		.empty   (empty),
		.level   (out_level)
	);

	// The back end's credit check must keep the pixel queue from overflowing.
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("pixel pushed into a full result queue");

	// The back end must only take commands that are present.
	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (cmd_level != '0))
		else $error("command popped from an empty queue");

	// The pixel that completes the image always ends its byte's output.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pixel.image_done) |-> pixel.last_of_run)
		else $error("image_done without last_of_run");

endmodule
